// ===== hw/rtl/sorted_double_ended_priority_queue_unit_defines.svh =====
// Assertion macros shared by the queue checker.
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SDEPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SDEPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

// ===== hw/rtl/sdepq_pkg.sv =====
// Package with the types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sdepq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 2'd0,
    MODE_REMOVE_MIN = 2'd1,
    MODE_REMOVE_MAX = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic occ;
    logic at_rear;
    logic pick;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sdepq_cell.sv =====
// One slot of the sorted store, with its compare and shift logic.
`timescale 1ns / 1ps
`default_nettype none
module sdepq_cell (
  input  wire logic                                    clk_i,
  input  wire sdepq_pkg::cell_ctrl_t                   ctrl_i,
  input  wire logic signed [sdepq_pkg::VALUE_W-1:0]    key_i,
  input  wire logic signed [sdepq_pkg::VALUE_W-1:0]    left_val_i,
  input  wire logic                                    left_gt_i,
  output logic signed [sdepq_pkg::VALUE_W-1:0]         val_o,
  output logic                                         gt_o,
  output logic signed [sdepq_pkg::VALUE_W-1:0]         tap_o
);

  logic signed [sdepq_pkg::VALUE_W-1:0] val_q, val_d;
  logic                                 shift, place;

  assign gt_o  = ctrl_i.occ & (key_i < val_q);
  assign shift = ctrl_i.ins & left_gt_i;
  assign place = ctrl_i.ins & ~left_gt_i & (gt_o | ctrl_i.at_rear);

  always_comb begin
    val_d = val_q;
    if (shift) begin
      val_d = left_val_i;
    end else if (place) begin
      val_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign tap_o = ctrl_i.pick ? val_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_double_ended_priority_queue_unit.sv =====
// Latency: a result appears in the cycle after its input transfer. Throughput: one
// transfer per cycle unless the output stalls, since every cell of the row compares
// and shifts in the same cycle and the removal read is one select over the cells.
// Reset clears both indices and the output valid and sets capacity to 16.
// The store itself is not cleared; only slots written by an insert are read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_double_ended_priority_queue_unit #(
  parameter int DEPTH = sdepq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sdepq_pkg::CAP_W-1:0]       cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // value
  input  wire logic [sdepq_pkg::VALUE_W-1:0]     s_axis_tdata,
  // mode
  input  wire logic [sdepq_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // removed_value
  output logic [sdepq_pkg::VALUE_W-1:0]          m_axis_tdata,
  // status [1:0], now_empty [2]
  output logic [sdepq_pkg::STATUS_W:0]           m_axis_tuser
);

  localparam int IdxW = $clog2(DEPTH + 1);
  localparam int CmpW = (IdxW > sdepq_pkg::CAP_W) ? IdxW : sdepq_pkg::CAP_W;

  logic [sdepq_pkg::CAP_W-1:0]    cap_q;
  logic [IdxW-1:0]                front_q, front_d, rear_q, rear_d;
  logic                           out_valid_q;
  logic [sdepq_pkg::VALUE_W-1:0]  out_data_q;
  logic [sdepq_pkg::STATUS_W-1:0] out_status_q;
  logic                           out_empty_q;

  logic [CmpW-1:0]                cap_ext, eff_cap;
  logic                           fire, empty, full;
  logic                           ins, pick_min, pick_max;
  logic [sdepq_pkg::STATUS_W-1:0] status;
  logic [sdepq_pkg::VALUE_W-1:0]  removed, tap_or;
  logic [IdxW-1:0]                front_inc, rear_dec;

  sdepq_pkg::cell_ctrl_t                  ctrl [DEPTH];
  logic signed [sdepq_pkg::VALUE_W-1:0]   val  [DEPTH];
  logic signed [sdepq_pkg::VALUE_W-1:0]   tap  [DEPTH];
  logic                                   gt   [DEPTH];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign fire          = s_axis_tvalid & s_axis_tready;

  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(DEPTH)) begin
      eff_cap = CmpW'(DEPTH);
    end
  end

  assign empty     = (rear_q == '0);
  assign full      = (CmpW'(rear_q) >= eff_cap);
  assign front_inc = front_q + IdxW'(1);
  assign rear_dec  = rear_q - IdxW'(1);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    ins      = 1'b0;
    pick_min = 1'b0;
    pick_max = 1'b0;
    removed  = '0;
    status   = sdepq_pkg::STATUS_DONE;
    unique case (s_axis_tuser)
      sdepq_pkg::MODE_INSERT: begin
        if (full) begin
          status = sdepq_pkg::STATUS_OVERFLOW;
        end else begin
          ins    = 1'b1;
          rear_d = rear_q + IdxW'(1);
        end
      end
      sdepq_pkg::MODE_REMOVE_MIN: begin
        if (empty) begin
          status = sdepq_pkg::STATUS_UNDERFLOW;
        end else begin
          pick_min = 1'b1;
          removed  = tap_or;
          if (front_inc >= rear_q) begin
            front_d = '0;
            rear_d  = '0;
          end else begin
            front_d = front_inc;
          end
        end
      end
      sdepq_pkg::MODE_REMOVE_MAX: begin
        if (empty) begin
          status = sdepq_pkg::STATUS_UNDERFLOW;
        end else begin
          pick_max = 1'b1;
          removed  = tap_or;
          if (rear_dec <= front_q) begin
            front_d = '0;
            rear_d  = '0;
          end else begin
            rear_d = rear_dec;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].ins     = fire & ins;
    assign ctrl[i].occ     = (IdxW'(i) >= front_q) & (IdxW'(i) < rear_q);
    assign ctrl[i].at_rear = (IdxW'(i) == rear_q);
    assign ctrl[i].pick    = (pick_min & (IdxW'(i) == front_q))
                           | (pick_max & (IdxW'(i + 1) == rear_q));
    if (i == 0) begin : g_first
      sdepq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl[i]),
        .key_i      (s_axis_tdata),
        .left_val_i ('0),
        .left_gt_i  (1'b0),
        .val_o      (val[i]),
        .gt_o       (gt[i]),
        .tap_o      (tap[i])
      );
    end else begin : g_rest
      sdepq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl[i]),
        .key_i      (s_axis_tdata),
        .left_val_i (val[i-1]),
        .left_gt_i  (gt[i-1]),
        .val_o      (val[i]),
        .gt_o       (gt[i]),
        .tap_o      (tap[i])
      );
    end
  end

  always_comb begin
    tap_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | tap[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= sdepq_pkg::CAP_RESET;
      front_q     <= '0;
      rear_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (fire) begin
        front_q     <= front_d;
        rear_q      <= rear_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q   <= removed;
      out_status_q <= status;
      out_empty_q  <= (rear_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_empty_q, out_status_q};

endmodule
`default_nettype wire

// ===== hw/rtl/sdepq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_double_ended_priority_queue_unit_defines.svh"
module sdepq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [sdepq_pkg::CAP_W-1:0]       cfg_data_i,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [sdepq_pkg::VALUE_W-1:0]     s_axis_tdata,
  input wire logic [sdepq_pkg::MODE_W-1:0]      s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [sdepq_pkg::VALUE_W-1:0]     m_axis_tdata,
  input wire logic [sdepq_pkg::STATUS_W:0]      m_axis_tuser
);

  logic unused;
  assign unused = cfg_valid_i ^ cfg_ready_o ^ (^cfg_data_i) ^ (^s_axis_tdata);

  `SDEPQ_ASSERT_NOW(a_underflow_zero,
    m_axis_tvalid && m_axis_tuser[1:0] == sdepq_pkg::STATUS_UNDERFLOW,
    m_axis_tdata == '0 && m_axis_tuser[2])
  `SDEPQ_ASSERT_NOW(a_overflow_not_empty,
    m_axis_tvalid && m_axis_tuser[1:0] == sdepq_pkg::STATUS_OVERFLOW,
    !m_axis_tuser[2] && m_axis_tdata == '0)
  `SDEPQ_ASSERT_NEXT(a_insert_result,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == sdepq_pkg::MODE_INSERT,
    m_axis_tvalid && m_axis_tdata == '0 && !m_axis_tuser[2])
  `SDEPQ_ASSERT_NEXT(a_stall_hold,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind sorted_double_ended_priority_queue_unit sdepq_checker u_sdepq_checker (.*);
`default_nettype wire

// ===== bench/sdepq_result_checker.sv =====
// Result checker that predicts and compares each queue response of the sorted priority queue.
`timescale 1ns / 1ps
module sdepq_result_checker #(
  parameter int DEPTH = sdepq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_i,
  input  wire logic [sdepq_pkg::CAP_W-1:0]       cfg_data_i,
  input  wire logic                              req_valid_i,
  input  wire logic                              req_ready_i,
  // value
  input  wire logic [sdepq_pkg::VALUE_W-1:0]     req_data_i,
  // mode
  input  wire logic [sdepq_pkg::MODE_W-1:0]      req_user_i,
  input  wire logic                              rsp_valid_i,
  input  wire logic                              rsp_ready_i,
  // removed_value
  input  wire logic [sdepq_pkg::VALUE_W-1:0]     rsp_data_i,
  // status [1:0], now_empty [2]
  input  wire logic [sdepq_pkg::STATUS_W:0]      rsp_user_i,
  output int                                     mismatch_count_o,
  output int                                     waiting_count_o,
  output int                                     checked_count_o,
  output int                                     overflow_count_o,
  output int                                     underflow_count_o
);
  import sdepq_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] removed;
    status_e            status;
    logic               empty;
  } queue_result_t;

  logic signed [VALUE_W-1:0] sorted_cells [DEPTH];
  int                        front_slot;
  int                        rear_slot;
  logic [CAP_W-1:0]          capacity;
  queue_result_t             pending_results [$];
  queue_result_t             oldest;

  initial begin
    mismatch_count_o  = 0;
    waiting_count_o   = 0;
    checked_count_o   = 0;
    overflow_count_o  = 0;
    underflow_count_o = 0;
    front_slot        = 0;
    rear_slot         = 0;
    capacity          = CAP_RESET;
  end

  function automatic queue_result_t predict_queue_op(logic [MODE_W-1:0] mode,
                                                     logic signed [VALUE_W-1:0] value);
    queue_result_t res;
    int            limit;
    int            j;
    res.removed = '0;
    res.status  = STATUS_DONE;
    limit = (capacity == '0) ? 1 : ((int'(capacity) > DEPTH) ? DEPTH : int'(capacity));
    case (mode)
      MODE_INSERT: begin
        if (rear_slot >= limit) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          j = rear_slot;
          while (j > front_slot && value < sorted_cells[j-1]) begin
            sorted_cells[j] = sorted_cells[j-1];
            j--;
          end
          sorted_cells[j] = value;
          rear_slot++;
        end
      end
      MODE_REMOVE_MIN, MODE_REMOVE_MAX: begin
        if (front_slot >= rear_slot) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          if (mode == MODE_REMOVE_MIN) begin
            res.removed = sorted_cells[front_slot];
            front_slot++;
          end else begin
            rear_slot--;
            res.removed = sorted_cells[rear_slot];
          end
          if (front_slot >= rear_slot) begin
            front_slot = 0;
            rear_slot  = 0;
          end
        end
      end
      default: ;
    endcase
    res.empty = (rear_slot == 0);
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    mismatch_count_o++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      front_slot = 0;
      rear_slot  = 0;
      capacity   = CAP_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      if (req_valid_i && req_ready_i) begin
        pending_results.push_back(predict_queue_op(req_user_i, req_data_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        checked_count_o++;
        if (rsp_user_i[STATUS_W-1:0] == STATUS_OVERFLOW) overflow_count_o++;
        if (rsp_user_i[STATUS_W-1:0] == STATUS_UNDERFLOW) underflow_count_o++;
        if (pending_results.size() == 0) begin
          flag_mismatch("unrequested transfer", '0, rsp_data_i);
        end else begin
          oldest = pending_results.pop_front();
          if (rsp_data_i !== oldest.removed) begin
            flag_mismatch("removed_value", oldest.removed, rsp_data_i);
          end
          if (rsp_user_i[STATUS_W-1:0] !== oldest.status) begin
            flag_mismatch("status", 32'(oldest.status), 32'(rsp_user_i[STATUS_W-1:0]));
          end
          if (rsp_user_i[STATUS_W] !== oldest.empty) begin
            flag_mismatch("now_empty", 32'(oldest.empty), 32'(rsp_user_i[STATUS_W]));
          end
        end
      end
    end
    waiting_count_o = pending_results.size();
  end

endmodule

// ===== bench/sorted_double_ended_priority_queue_unit_tb.sv =====
// Testbench top that drives the sorted priority queue and reports the verdict.
`timescale 1ns / 1ps
module sorted_double_ended_priority_queue_unit_tb;
  import sdepq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [VALUE_W-1:0]   s_tdata;
  logic [MODE_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;
  logic [STATUS_W:0]    m_tuser;

  int mismatches;
  int waiting;
  int checked;
  int overflows;
  int underflows;
  int sent_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  sorted_double_ended_priority_queue_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  sdepq_result_checker queue_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .req_valid_i       (s_tvalid),
    .req_ready_i       (s_tready),
    .req_data_i        (s_tdata),
    .req_user_i        (s_tuser),
    .rsp_valid_i       (m_tvalid),
    .rsp_ready_i       (m_tready),
    .rsp_data_i        (m_tdata),
    .rsp_user_i        (m_tuser),
    .mismatch_count_o  (mismatches),
    .waiting_count_o   (waiting),
    .checked_count_o   (checked),
    .overflow_count_o  (overflows),
    .underflow_count_o (underflows)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_item(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(int count);
    bit               filling;
    int               roll;
    logic [MODE_W-1:0] mode;
    filling = 1'b1;
    repeat (count) begin
      if ($urandom_range(29) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 3) begin
        mode = MODE_UNUSED;
      end else if (roll < (filling ? 78 : 25)) begin
        mode = MODE_INSERT;
      end else begin
        mode = $urandom_range(1) ? MODE_REMOVE_MIN : MODE_REMOVE_MAX;
      end
      if ($urandom_range(59) == 0) drain();
      push_item(mode, pick_value());
    end
  endtask

  logic [CAP_W-1:0] cap_plan [8] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd1, 5'd17, 5'd16};

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_INSERT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_item(MODE_REMOVE_MIN, '0);
    push_item(MODE_REMOVE_MAX, 32'hffff_ffff);
    push_item(MODE_UNUSED, 32'h1234_5678);
    push_item(MODE_INSERT, 32'h7fff_ffff);
    push_item(MODE_INSERT, 32'h8000_0000);
    push_item(MODE_INSERT, 32'h0000_0000);
    push_item(MODE_INSERT, 32'hffff_ffff);
    push_item(MODE_INSERT, 32'h0000_0000);
    push_item(MODE_INSERT, 32'h0000_0001);
    push_item(MODE_UNUSED, 32'hffff_ffff);
    push_item(MODE_REMOVE_MIN, '0);
    push_item(MODE_REMOVE_MAX, '0);
    push_item(MODE_REMOVE_MIN, '0);
    push_item(MODE_INSERT, 32'h8000_0000);
    push_item(MODE_REMOVE_MAX, '0);
    push_item(MODE_REMOVE_MAX, '0);
    push_item(MODE_REMOVE_MIN, '0);
    push_item(MODE_REMOVE_MIN, '0);
    write_capacity(5'd1);
    push_item(MODE_INSERT, 32'h0000_0005);
    push_item(MODE_INSERT, 32'h0000_0006);
    push_item(MODE_REMOVE_MAX, '0);
    push_item(MODE_REMOVE_MIN, '0);

    for (int seg = 0; seg < 8; seg++) begin
      if (seg < 3) begin
        send_idle = 36;
        recv_idle = 69;
      end else if (seg < 6) begin
        send_idle = 69;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_capacity(cap_plan[seg]);
      random_items(100);
    end

    drain();
    repeat (4) @(negedge clk);
    $display("Sent %0d requests and checked %0d responses across eight capacity settings,",
             sent_count, checked);
    $display("including %0d overflows and %0d underflows.", overflows, underflows);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sorted_double_ended_priority_queue_unit.f =====
+incdir+hw/rtl
hw/rtl/sdepq_pkg.sv
hw/rtl/sdepq_cell.sv
hw/rtl/sorted_double_ended_priority_queue_unit.sv
hw/rtl/sdepq_checker.sv
bench/sdepq_result_checker.sv
bench/sorted_double_ended_priority_queue_unit_tb.sv
